>>> src/utf8_text_sanitizer_core_macros.svh
// Assertion macros for the UTF-8 text sanitizer core.
`ifndef UTF8_TEXT_SANITIZER_CORE_MACROS_SVH
`define UTF8_TEXT_SANITIZER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/utf8ts_pkg.sv
// Shared types for the UTF-8 text sanitizer core.
package utf8ts_pkg;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } raw_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_text;
  } clean_req_t;

  // One decoded input: up to four output bytes.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            fin;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> src/utf8_text_sanitizer_core.sv
// Top level of the UTF-8 text sanitizer: decoder, run queue and output serializer.
//
//   channel | direction | payload      | accepted when
//   raw     | in        | raw_req_t    | raw_valid && raw_ready
//   clean   | out       | clean_req_t  | clean_valid && clean_ready
//
// One input byte per cycle is decoded while raw_ready is high, into a run of 0 to 4 output bytes;
// only non-empty runs are queued. The serializer sends one output byte per cycle while clean_ready is high.
// raw_ready drops only while the QUEUE_DEPTH-entry run queue is full.
// Synchronous reset closes any open sequence and empties the queue; no clearing pass.
`include "utf8_text_sanitizer_core_macros.svh"

module utf8_text_sanitizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   raw_valid,
  output logic                   raw_ready,
  input  utf8ts_pkg::raw_req_t   raw,
  output logic                   clean_valid,
  input  logic                   clean_ready,
  output utf8ts_pkg::clean_req_t clean
);
  import utf8ts_pkg::*;

  logic      push;
  logic      pop;
  logic      seq_open;
  run_t      push_run;
  run_t      head;
  q_status_t q_stat;

  utf8ts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_ready (raw_ready),
    .raw       (raw),
    .q_full    (q_stat.full),
    .push      (push),
    .run       (push_run),
    .seq_open  (seq_open)
  );

  utf8ts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .status   (q_stat)
  );

  utf8ts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (q_stat.empty),
    .pop         (pop),
    .clean_valid (clean_valid),
    .clean_ready (clean_ready),
    .clean       (clean)
  );

  `UTS_ASSERT_NEXT(a_final_closes, raw_valid && raw_ready && raw.is_final, !seq_open, "sequence open after final byte")
  `UTS_ASSERT_NEXT(a_ascii_emits, raw_valid && raw_ready && !seq_open && !raw.in_byte[7], clean_valid, "ASCII byte gave no output")
  `UTS_ASSERT_NEXT(a_run_unbroken, clean_valid && clean_ready && !clean.last_of_run, clean_valid, "run broken mid-way")
  `UTS_ASSERT_NOW(a_eot_last, clean_valid && clean.end_of_text, clean.last_of_run, "end of text not on last byte of run")

endmodule

>>> src/utf8ts_front.sv
// Front end: UTF-8 decode and classification of each input byte into an output run.
module utf8ts_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                raw_valid,
  output logic                raw_ready,
  input  utf8ts_pkg::raw_req_t raw,
  input  logic                q_full,
  output logic                push,
  output utf8ts_pkg::run_t    run,
  output logic                seq_open
);
  import utf8ts_pkg::*;

  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;

  function automatic logic glyph_unsupported(input logic [20:0] c);
    return c == 21'h0000A0 || c == 21'h0000AD || c == 21'h001680 ||
           c == 21'h00180E || c == 21'h00FFFD || c == 21'h003000 ||
           (c >= 21'h002000 && c <= 21'h00206F) ||
           (c >= 21'h002500 && c <= 21'h0025FF) ||
           (c >= 21'h00FFF0 && c <= 21'h00FFFF);
  endfunction

  logic [7:0]  held [3];
  logic [7:0]  held_next [3];
  logic [2:0]  exp_len, exp_len_next;
  logic [1:0]  n_held, n_held_next;
  logic [20:0] cp, cp_next;

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic        cont;
  logic [20:0] cp_ext;
  logic [2:0]  have;
  logic [2:0]  cnt;
  logic [20:0] minimum;
  logic        bad;
  logic        do_start;
  logic        ctrl;
  logic [2:0]  lead_len;
  logic [20:0] lead_bits;
  logic [1:0]  pos;

  assign raw_ready = !q_full;
  assign accept    = raw_valid && raw_ready;
  assign seq_open  = exp_len != 3'd0 && n_held != 2'd0;

  always_comb begin
    b         = raw.in_byte;
    fin       = raw.is_final;
    cont      = b[7:6] == 2'b10;
    cp_ext    = {cp[14:0], b[5:0]};
    have      = {1'b0, n_held} + 3'd1;
    ctrl      = b < 8'h20 && b != 8'h0A && b != 8'h09;
    if (b[7:5] == 3'b110) begin
      lead_len  = 3'd2;
      lead_bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_len  = 3'd3;
      lead_bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_len  = 3'd4;
      lead_bits = {18'd0, b[2:0]};
    end else begin
      lead_len  = 3'd0;
      lead_bits = '0;
    end
    case (exp_len)
      3'd2:    minimum = 21'h000080;
      3'd3:    minimum = 21'h000800;
      default: minimum = 21'h010000;
    endcase
    bad = cp_ext < minimum || cp_ext > CP_MAX || (cp_ext >= SURR_LO && cp_ext <= SURR_HI);

    run.bytes    = {4{SPACE_BYTE}};
    cnt          = 3'd0;
    do_start     = 1'b0;
    held_next    = held;
    exp_len_next = exp_len;
    n_held_next  = n_held;
    cp_next      = cp;

    if (!seq_open) begin
      do_start = 1'b1;
    end else if (!cont) begin
      cnt      = {1'b0, n_held};
      do_start = 1'b1;
    end else if (have >= exp_len) begin
      if (bad) begin
        cnt = have;
      end else if (glyph_unsupported(cp_ext)) begin
        cnt = 3'd1;
      end else begin
        run.bytes[0] = held[0];
        run.bytes[1] = (n_held > 2'd1) ? held[1] : b;
        run.bytes[2] = (n_held > 2'd2) ? held[2] : b;
        run.bytes[3] = b;
        cnt          = have;
      end
      exp_len_next = 3'd0;
      n_held_next  = 2'd0;
      cp_next      = '0;
    end else if (fin) begin
      cnt = have;
    end else begin
      held_next[n_held] = b;
      n_held_next       = have[1:0];
      cp_next           = cp_ext;
    end

    pos = cnt[1:0];
    if (do_start) begin
      exp_len_next = 3'd0;
      n_held_next  = 2'd0;
      cp_next      = '0;
      if (!b[7]) begin
        run.bytes[pos] = ctrl ? SPACE_BYTE : b;
        cnt            = cnt + 3'd1;
      end else if (lead_len == 3'd0 || fin) begin
        run.bytes[pos] = SPACE_BYTE;
        cnt            = cnt + 3'd1;
      end else begin
        held_next[0] = b;
        n_held_next  = 2'd1;
        exp_len_next = lead_len;
        cp_next      = lead_bits;
      end
    end

    if (fin) begin
      exp_len_next = 3'd0;
      n_held_next  = 2'd0;
      cp_next      = '0;
    end

    run.last_idx = 2'(cnt - 3'd1);
    run.fin      = fin;
    push         = accept && cnt != 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= 3'd0;
      n_held  <= 2'd0;
      cp      <= '0;
      held[0] <= 8'd0;
      held[1] <= 8'd0;
      held[2] <= 8'd0;
    end else if (accept) begin
      exp_len <= exp_len_next;
      n_held  <= n_held_next;
      cp      <= cp_next;
      held    <= held_next;
    end
  end

endmodule

>>> src/utf8ts_queue.sv
// Run queue between the decoder and the output serializer.
module utf8ts_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  utf8ts_pkg::run_t     push_run,
  input  logic                 pop,
  output utf8ts_pkg::run_t     head,
  output utf8ts_pkg::q_status_t status
);
  import utf8ts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> src/utf8ts_back.sv
// Back end: serializes queued runs into one output byte per request.
module utf8ts_back (
  input  logic                   clk,
  input  logic                   rst,
  input  utf8ts_pkg::run_t       head,
  input  logic                   empty,
  output logic                   pop,
  output logic                   clean_valid,
  input  logic                   clean_ready,
  output utf8ts_pkg::clean_req_t clean
);
  import utf8ts_pkg::*;

  logic [1:0] idx;
  logic       last;
  logic       accept;

  assign last              = idx == head.last_idx;
  assign clean_valid       = !empty;
  assign accept            = clean_valid && clean_ready;
  assign pop               = accept && last;
  assign clean.out_byte    = head.bytes[idx];
  assign clean.last_of_run = last;
  assign clean.end_of_text = last && head.fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (accept) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

>>> dv/tb_utf8_text_sanitizer_core.sv
// Testbench for utf8_text_sanitizer_core: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps

module tb_utf8_text_sanitizer_core;
  import utf8ts_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       raw_valid = 1'b0;
  logic       raw_ready;
  raw_req_t   raw = '0;
  logic       clean_valid;
  logic       clean_ready = 1'b0;
  clean_req_t clean;

  int idle_pct = 0;
  int stall_pct = 0;
  int raw_sent = 0;
  int fail_count = 0;

  // open multibyte sequence
  logic [7:0]  seq_bytes [3];
  logic [2:0]  seq_len;
  logic [1:0]  seq_cnt;
  logic [20:0] seq_cp;

  logic [7:0]  run_bytes [$];
  clean_req_t  clean_expected [$];

  utf8_text_sanitizer_core u_top (
    .clk         (clk),
    .rst         (rst),
    .raw_valid   (raw_valid),
    .raw_ready   (raw_ready),
    .raw         (raw),
    .clean_valid (clean_valid),
    .clean_ready (clean_ready),
    .clean       (clean)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    clean_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  function automatic logic unsupported_glyph(input logic [20:0] cp);
    return cp == 21'h00A0 || cp == 21'h00AD || cp == 21'h1680 || cp == 21'h180E ||
           cp == 21'hFFFD || cp == 21'h3000 ||
           (cp >= 21'h2000 && cp <= 21'h206F) ||
           (cp >= 21'h2500 && cp <= 21'h25FF) ||
           (cp >= 21'hFFF0 && cp <= 21'hFFFF);
  endfunction

  task automatic close_seq();
    seq_bytes = '{8'h00, 8'h00, 8'h00};
    seq_len = '0;
    seq_cnt = '0;
    seq_cp = '0;
  endtask

  task automatic add_byte(input logic [7:0] v);
    run_bytes = {run_bytes, v};
  endtask

  // byte with no sequence open: pass, replace or open a sequence
  task automatic start_char(input logic [7:0] b, input logic fin);
    logic [2:0]  len;
    logic [20:0] bits;
    len = 3'd0;
    bits = '0;
    if (b < 8'h80) begin
      add_byte((b < 8'h20 && b != 8'h0A && b != 8'h09) ? SPACE_BYTE : b);
      return;
    end
    if (b[7:5] == 3'b110) begin
      len = 3'd2;
      bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
      bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
      bits = {18'd0, b[2:0]};
    end
    if (len == 3'd0 || fin) begin
      add_byte(SPACE_BYTE);
      return;
    end
    seq_bytes[0] = b;
    seq_cnt = 2'd1;
    seq_len = len;
    seq_cp = bits;
  endtask

  task automatic sanitize_byte(input logic [7:0] b, input logic fin);
    logic [20:0] cp;
    logic [20:0] lo;
    int          have;
    clean_req_t  r;
    run_bytes.delete();
    if (seq_len == 3'd0 || seq_cnt == 2'd0) begin
      close_seq();
      start_char(b, fin);
    end else if (b[7:6] != 2'b10) begin
      repeat (seq_cnt) add_byte(SPACE_BYTE);
      close_seq();
      start_char(b, fin);
    end else begin
      cp = {seq_cp[14:0], b[5:0]};
      have = seq_cnt + 1;
      if (have >= seq_len) begin
        lo = (seq_len == 3'd2) ? 21'h80 : (seq_len == 3'd3) ? 21'h800 : 21'h10000;
        if (cp < lo || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
          repeat (have) add_byte(SPACE_BYTE);
        end else if (unsupported_glyph(cp)) begin
          add_byte(SPACE_BYTE);
        end else begin
          for (int i = 0; i < seq_cnt; i++) add_byte(seq_bytes[i]);
          add_byte(b);
        end
        close_seq();
      end else if (fin) begin
        repeat (have) add_byte(SPACE_BYTE);
        close_seq();
      end else begin
        seq_bytes[seq_cnt] = b;
        seq_cnt = seq_cnt + 2'd1;
        seq_cp = cp;
      end
    end
    if (fin) close_seq();
    foreach (run_bytes[i]) begin
      r.out_byte = run_bytes[i];
      r.last_of_run = (i == run_bytes.size() - 1);
      r.end_of_text = fin && (i == run_bytes.size() - 1);
      clean_expected = {clean_expected, r};
    end
  endtask

  // predict on accepted raw requests, then check accepted clean requests
  always @(posedge clk) begin : monitor
    clean_req_t want;
    if (!rst) begin
      if (raw_valid && raw_ready) sanitize_byte(raw.in_byte, raw.is_final);
      if (clean_valid && clean_ready) begin
        if (clean_expected.size() == 0) begin
          $error("unexpected clean request: out_byte %h", clean.out_byte);
          fail_count++;
        end else begin
          want = clean_expected.pop_front();
          if (clean.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, clean.out_byte);
            fail_count++;
          end
          if (clean.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, clean.last_of_run);
            fail_count++;
          end
          if (clean.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %b, got %b", want.end_of_text, clean.end_of_text);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      raw_valid <= 1'b0;
      @(posedge clk);
    end
    raw_valid <= 1'b1;
    raw <= '{in_byte: b, is_final: fin};
    do @(posedge clk); while (!raw_ready);
    raw_sent++;
  endtask

  task automatic wait_drain();
    raw_valid <= 1'b0;
    @(posedge clk);
    while (clean_expected.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic random_fin();
    return $urandom_range(19) == 0;
  endfunction

  // encode cp in len bytes (longer than needed gives an overlong form), send first keep bytes
  task automatic send_utf8(input logic [20:0] cp, input int len, input int keep);
    logic [7:0] enc [4];
    enc = '{8'h00, 8'h00, 8'h00, 8'h00};
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(enc[i], random_fin());
  endtask

  task automatic test_ascii_controls();
    send_byte(8'h00, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_valid_sequences();
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  task automatic test_unsupported_glyphs();
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBD, 1'b0);
  endtask

  task automatic test_malformed_sequences();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hF0, 1'b1);
  endtask

  task automatic test_random_text(input int idle, input int stall, input int count,
                                  input logic pause_midway);
    int          start;
    int          kind;
    int          len;
    logic [20:0] cp;
    logic        paused;
    start = raw_sent;
    paused = 1'b0;
    idle_pct = idle;
    stall_pct = stall;
    while (raw_sent - start < count) begin
      kind = $urandom_range(99);
      if (pause_midway && !paused && raw_sent - start >= count / 2) begin
        wait_drain();
        paused = 1'b1;
      end
      if (kind < 30) begin
        send_byte(8'($urandom_range(127)), random_fin());
      end else if (kind < 60) begin
        len = $urandom_range(2, 4);
        cp = 21'((len == 2) ? $urandom_range(21'h80, 21'h7FF) :
                 (len == 3) ? $urandom_range(21'h800, 21'hFFFF) :
                              $urandom_range(21'h10000, 21'h10FFFF));
        send_utf8(cp, len, len);
      end else if (kind < 70) begin
        case ($urandom_range(8))
          0: cp = 21'h00A0;
          1: cp = 21'h00AD;
          2: cp = 21'h1680;
          3: cp = 21'h180E;
          4: cp = 21'h3000;
          5: cp = 21'hFFFD;
          6: cp = 21'($urandom_range(21'h2000, 21'h206F));
          7: cp = 21'($urandom_range(21'h2500, 21'h25FF));
          default: cp = 21'($urandom_range(21'hFFF0, 21'hFFFF));
        endcase
        len = (cp < 21'h800) ? 2 : 3;
        send_utf8(cp, len, len);
      end else if (kind < 75) begin
        len = $urandom_range(2, 4);
        cp = 21'((len == 2) ? $urandom_range(21'h7F) :
                 (len == 3) ? $urandom_range(21'h7FF) : $urandom_range(21'hFFFF));
        send_utf8(cp, len, len);
      end else if (kind < 80) begin
        send_utf8(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3);
      end else if (kind < 85) begin
        send_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
      end else if (kind < 92) begin
        len = $urandom_range(2, 4);
        cp = 21'((len == 2) ? $urandom_range(21'h80, 21'h7FF) :
                 (len == 3) ? $urandom_range(21'h800, 21'hFFFF) :
                              $urandom_range(21'h10000, 21'h10FFFF));
        send_utf8(cp, len, $urandom_range(1, len - 1));
      end else begin
        send_byte(8'($urandom_range(255)), random_fin());
      end
    end
  endtask

  initial begin
    close_seq();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_ascii_controls();
    test_valid_sequences();
    test_unsupported_glyphs();
    test_malformed_sequences();
    wait_drain();
    test_random_text(0, 0, 60, 1'b1);
    wait_drain();
    test_random_text(47, 0, 60, 1'b0);
    wait_drain();
    test_random_text(0, 47, 60, 1'b0);
    wait_drain();
    test_random_text(35, 35, 60, 1'b0);
    wait_drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && clean_expected.size() == 0) begin
      $display("utf8_text_sanitizer_core verification clean");
    end else begin
      $display("utf8_text_sanitizer_core verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("utf8_text_sanitizer_core verification failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/utf8ts_pkg.sv
src/utf8ts_front.sv
src/utf8ts_queue.sv
src/utf8ts_back.sv
src/utf8_text_sanitizer_core.sv
dv/tb_utf8_text_sanitizer_core.sv
